@@ rtl/assert_macros.svh @@
// Assertion macros for the key event dedup block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DSK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DSK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSK_ASSERT(label, prop, msg)
`define DSK_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/dsk_pkg.sv @@
package dsk_pkg;

  localparam int DEF_KEY_CODES   = 256;
  localparam int DEF_QUEUE_DEPTH = 16;

  // register indexes
  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_LIFETIME = 2'd1;
  localparam logic [1:0] REG_DELAY    = 2'd2;

  typedef enum logic [1:0] {
    OP_RAW  = 2'd0,
    OP_HOOK = 2'd1,
    OP_POLL = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_NOP  = 2'd0,
    CMD_RAW  = 2'd1,
    CMD_HOOK = 2'd2,
    CMD_POLL = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  key;
    logic [31:0] msg;
    logic [63:0] now;
  } cmd_t;

  typedef struct packed {
    logic [15:0] window;
    logic [15:0] lifetime;
    logic [15:0] delay;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PRUNE,
    B_SEARCH,
    B_SCAN,
    B_FLUSH,
    B_RESULT
  } back_state_t;

endpackage

@@ rtl/dual_source_key_event_dedup_top.sv @@
// Two-source key press deduplicator.
// Input channel (in_valid/in_stall): opcode, key_code, key_down, message_time,
// arrival_time. Opcode raw or hook carries a key event, poll asks for pending
// hook presses that have waited out the fallback delay.
// Output channel (out_valid/out_stall): one result per event; a poll gives one
// result per released key (oldest first) or one empty result; last marks the
// final result of an item.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 window,
// 1 raw lifetime, 2 fallback delay; cfg_ready is always high. Write only idle.
// Timing: an item passes a two-item queue to a sequencer that walks the queues
// one entry per cycle, but a poll's scan waits while a held release meets a
// stalled output. An event prunes stale raw entries, then compares entries
// until a match ends the search or all are compared; a poll prunes, then walks
// the pending hooks. Each walk covers at most QUEUE_DEPTH entries. A release,
// repeat or unused opcode goes straight to its result.
// Held bitmaps are updated as the item is taken.
// Reset empties both queues and bitmaps and loads 50/250/30 ms. A stalled
// output holds its result; the sequencer waits, the queue fills, then in_stall.
module dual_source_key_event_dedup_top #(
  parameter int KEY_CODES   = dsk_pkg::DEF_KEY_CODES,
  parameter int QUEUE_DEPTH = dsk_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  key_code,
  input  logic        key_down,
  input  logic [31:0] message_time,
  input  logic [63:0] arrival_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [7:0]  ready_key,
  output logic        key_valid,
  output logic        overflow,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dsk_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full, q_avail, q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window   <= 16'd50;
      cfg.lifetime <= 16'd250;
      cfg.delay    <= 16'd30;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW:   cfg.window   <= cfg_data;
        REG_LIFETIME: cfg.lifetime <= cfg_data;
        REG_DELAY:    cfg.delay    <= cfg_data;
        default: ;
      endcase
    end
  end

  dsk_front #(.KEY_CODES(KEY_CODES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .take         (!q_full),
    .opcode       (opcode),
    .key_code     (key_code),
    .key_down     (key_down),
    .message_time (message_time),
    .arrival_time (arrival_time),
    .cmd          (front_cmd)
  );

  dsk_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (in_valid),
    .wdata (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .avail (q_avail),
    .rdata (q_cmd)
  );

  dsk_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_avail   (q_avail),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .accepted  (accepted),
    .ready_key (ready_key),
    .key_valid (key_valid),
    .overflow  (overflow),
    .last      (last)
  );

endmodule

@@ rtl/dsk_front.sv @@
module dsk_front #(
  parameter int KEY_CODES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              take,
  input  logic [1:0]        opcode,
  input  logic [7:0]        key_code,
  input  logic              key_down,
  input  logic [31:0]       message_time,
  input  logic [63:0]       arrival_time,
  output dsk_pkg::cmd_t     cmd
);
  import dsk_pkg::*;

  localparam int KW = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;

  logic [KEY_CODES-1:0] raw_held;
  logic [KEY_CODES-1:0] hook_held;
  logic [31:0]          key32;
  logic [KW-1:0]        kidx;
  logic                 in_range;
  logic                 is_raw;
  logic                 was_held;
  opcode_t              op;

  assign op       = opcode_t'(opcode);
  assign key32    = 32'(key_code);
  assign kidx     = key32[KW-1:0];
  assign in_range = key32 < 32'(KEY_CODES);
  assign is_raw   = (op == OP_RAW);
  assign was_held = is_raw ? raw_held[kidx] : hook_held[kidx];

  // classify: only a fresh press or a poll reaches the back end as work
  always_comb begin
    cmd.kind = CMD_NOP;
    cmd.key  = key_code;
    cmd.msg  = message_time;
    cmd.now  = arrival_time;
    case (op)
      OP_POLL: cmd.kind = CMD_POLL;
      OP_RAW, OP_HOOK: begin
        if (in_range && key_down && !was_held)
          cmd.kind = is_raw ? CMD_RAW : CMD_HOOK;
      end
      default: cmd.kind = CMD_NOP;
    endcase
  end

  // held bitmaps
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_held  <= '0;
      hook_held <= '0;
    end else if (in_valid && take && in_range) begin
      if (op == OP_RAW) raw_held[kidx] <= key_down;
      if (op == OP_HOOK) hook_held[kidx] <= key_down;
    end
  end

endmodule

@@ rtl/dsk_cmd_fifo.sv @@
module dsk_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dsk_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output dsk_pkg::cmd_t rdata
);
  import dsk_pkg::*;

  cmd_t       slot [2];
  logic       head;
  logic       tail;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign rdata = slot[head];

  // two-item queue between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) tail <= ~tail;
      if (pop && avail) head <= ~head;
      count <= count + 2'(push && !full) - 2'(pop && avail);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slot[tail] <= wdata;
  end

endmodule

@@ rtl/dsk_back.sv @@
`include "assert_macros.svh"
module dsk_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  dsk_pkg::cfg_t cfg,
  input  logic          q_avail,
  input  dsk_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          accepted,
  output logic [7:0]    ready_key,
  output logic          key_valid,
  output logic          overflow,
  output logic          last
);
  import dsk_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  // recent raw and pending hook queues, oldest at entry 0
  logic [7:0]  rkey [QUEUE_DEPTH];
  logic [31:0] rmsg [QUEUE_DEPTH];
  logic [63:0] rarr [QUEUE_DEPTH];
  logic [7:0]  pkey [QUEUE_DEPTH];
  logic [31:0] pmsg [QUEUE_DEPTH];
  logic [63:0] parr [QUEUE_DEPTH];
  logic [CW-1:0] rcount, pcount;

  back_state_t state, state_next;
  cmd_t        cur;
  logic [CW-1:0] idx, idx_next;
  logic        res_acc, res_acc_next;
  logic        res_ovf, res_ovf_next;
  logic        hold_v, hold_v_next;
  logic [7:0]  hold_key, hold_key_next;

  logic          slot_free;
  logic          load;
  logic          ld_acc, ld_kv, ld_ovf, ld_last;
  logic [7:0]    ld_key;
  logic          r_rm, r_push, p_rm, p_push;
  logic [IW-1:0] r_rm_idx, p_rm_idx;
  logic [IW-1:0] ri;
  logic [31:0]   d, gap;
  logic          tgt_key_eq;
  logic [31:0]   tgt_msg;
  logic [7:0]    tgt_key;
  logic          match;
  logic          stale;
  logic          due;
  logic [CW-1:0] tcount;

  assign slot_free = !out_valid || !out_stall;
  assign ri        = idx[IW-1:0];

  // search target: raw presses look in pending, hook presses in recent
  assign tcount  = (cur.kind == CMD_RAW) ? pcount : rcount;
  assign tgt_key = (cur.kind == CMD_RAW) ? pkey[ri] : rkey[ri];
  assign tgt_msg = (cur.kind == CMD_RAW) ? pmsg[ri] : rmsg[ri];
  assign tgt_key_eq = (tgt_key == cur.key);
  assign d     = tgt_msg - cur.msg;
  assign gap   = d[31] ? (32'd0 - d) : d;
  assign match = tgt_key_eq && (gap <= 32'(cfg.window));
  assign stale = (rcount != '0) && ((cur.now - rarr[0]) > 64'(cfg.lifetime));
  assign due   = (cur.now - parr[ri]) >= 64'(cfg.delay);

  // sequencer
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    res_acc_next  = res_acc;
    res_ovf_next  = res_ovf;
    hold_v_next   = hold_v;
    hold_key_next = hold_key;
    q_pop    = 1'b0;
    load     = 1'b0;
    ld_acc   = 1'b0;
    ld_key   = 8'd0;
    ld_kv    = 1'b0;
    ld_ovf   = 1'b0;
    ld_last  = 1'b1;
    r_rm     = 1'b0;
    r_push   = 1'b0;
    p_rm     = 1'b0;
    p_push   = 1'b0;
    r_rm_idx = '0;
    p_rm_idx = '0;
    case (state)
      B_IDLE: begin
        if (q_avail) begin
          q_pop        = 1'b1;
          res_acc_next = 1'b0;
          res_ovf_next = 1'b0;
          hold_v_next  = 1'b0;
          state_next   = (q_cmd.kind == CMD_NOP) ? B_RESULT : B_PRUNE;
        end
      end
      B_PRUNE: begin
        if (stale) begin
          r_rm = 1'b1;
        end else begin
          idx_next   = '0;
          state_next = (cur.kind == CMD_POLL) ? B_SCAN : B_SEARCH;
        end
      end
      B_SEARCH: begin
        if (idx == tcount) begin
          // no partner: queue the press
          res_acc_next = 1'b1;
          state_next   = B_RESULT;
          if (cur.kind == CMD_RAW) begin
            r_push       = 1'b1;
            res_ovf_next = (rcount == FULL);
            if (rcount == FULL) r_rm = 1'b1;
          end else begin
            p_push       = 1'b1;
            res_ovf_next = (pcount == FULL);
            if (pcount == FULL) p_rm = 1'b1;
          end
        end else if (match) begin
          res_acc_next = (cur.kind == CMD_RAW);
          state_next   = B_RESULT;
          if (cur.kind == CMD_RAW) begin
            p_rm     = 1'b1;
            p_rm_idx = ri;
          end else begin
            r_rm     = 1'b1;
            r_rm_idx = ri;
          end
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      B_SCAN: begin
        if (hold_v && !slot_free) begin
          state_next = B_SCAN;
        end else if (idx == pcount) begin
          state_next = B_FLUSH;
        end else if (due) begin
          p_rm          = 1'b1;
          p_rm_idx      = ri;
          hold_v_next   = 1'b1;
          hold_key_next = pkey[ri];
          // the earlier release is not the final one
          if (hold_v) begin
            load    = 1'b1;
            ld_key  = hold_key;
            ld_kv   = 1'b1;
            ld_last = 1'b0;
          end
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      B_FLUSH: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_key     = hold_v ? hold_key : 8'd0;
          ld_kv      = hold_v;
          state_next = B_IDLE;
        end
      end
      B_RESULT: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_acc     = res_acc;
          ld_ovf     = res_ovf;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      rcount <= '0;
      pcount <= '0;
      hold_v <= 1'b0;
    end else begin
      state  <= state_next;
      hold_v <= hold_v_next;
      if (r_push && !r_rm) rcount <= rcount + CW'(1);
      else if (r_rm && !r_push) rcount <= rcount - CW'(1);
      if (p_push && !p_rm) pcount <= pcount + CW'(1);
      else if (p_rm && !p_push) pcount <= pcount - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_cmd;
    idx      <= idx_next;
    res_acc  <= res_acc_next;
    res_ovf  <= res_ovf_next;
    hold_key <= hold_key_next;
  end

  // queue storage: removal shifts the tail down, push writes behind it
  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
      if (r_rm && (IW'(j) >= r_rm_idx)) begin
        rkey[j] <= rkey[j+1];
        rmsg[j] <= rmsg[j+1];
        rarr[j] <= rarr[j+1];
      end
      if (p_rm && (IW'(j) >= p_rm_idx)) begin
        pkey[j] <= pkey[j+1];
        pmsg[j] <= pmsg[j+1];
        parr[j] <= parr[j+1];
      end
    end
    if (r_push) begin
      rkey[(rcount == FULL) ? IW'(QUEUE_DEPTH - 1) : rcount[IW-1:0]] <= cur.key;
      rmsg[(rcount == FULL) ? IW'(QUEUE_DEPTH - 1) : rcount[IW-1:0]] <= cur.msg;
      rarr[(rcount == FULL) ? IW'(QUEUE_DEPTH - 1) : rcount[IW-1:0]] <= cur.now;
    end
    if (p_push) begin
      pkey[(pcount == FULL) ? IW'(QUEUE_DEPTH - 1) : pcount[IW-1:0]] <= cur.key;
      pmsg[(pcount == FULL) ? IW'(QUEUE_DEPTH - 1) : pcount[IW-1:0]] <= cur.msg;
      parr[(pcount == FULL) ? IW'(QUEUE_DEPTH - 1) : pcount[IW-1:0]] <= cur.now;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      accepted  <= ld_acc;
      ready_key <= ld_key;
      key_valid <= ld_kv;
      overflow  <= ld_ovf;
      last      <= ld_last;
    end
  end

  `DSK_ASSERT(a_counts_bounded, (rcount <= FULL) && (pcount <= FULL), "queue count past depth")
  `DSK_ASSERT(a_pop_idle, q_pop |-> (state == B_IDLE), "command taken while busy")
  `DSK_ASSERT(a_release_clean, (out_valid && key_valid) |-> (!accepted && !overflow), "released key result carries event flags")
  `DSK_ASSERT(a_no_overwrite, (out_valid && out_stall) |-> !load, "stalled result overwritten")

endmodule
